// ===== rtl/lpr_pkg.sv =====
// package with shared types and constants of the line pixel rasterizer
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int unsigned COORD_W  = 15;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned LIMIT_W  = 12;
    localparam int unsigned COLOUR_W = 24;

    localparam logic [LIMIT_W-1:0] RESET_WIDTH  = 12'd127;
    localparam logic [LIMIT_W-1:0] RESET_HEIGHT = 12'd159;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic                    steep;
        logic signed [POS_W-1:0] major_pos;
        logic signed [POS_W-1:0] major_end;
        logic signed [POS_W-1:0] minor_pos;
        logic signed [POS_W-1:0] major_delta;
        logic signed [POS_W-1:0] minor_delta;
        logic signed [POS_W-1:0] error_term;
        logic                    minor_down;
    } t_line_setup;

endpackage

// ===== rtl/lpr_setup.sv =====
// line setup: axis swap, endpoint ordering, deltas and initial error
`timescale 1ns / 1ps

module lpr_setup
    import lpr_pkg::*;
(
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    output t_line_setup               o_setup
);

    logic signed [POS_W-1:0] w_sx, w_sy, w_ex, w_ey;
    logic signed [POS_W-1:0] w_dx, w_dy, w_adx, w_ady;
    logic signed [POS_W-1:0] w_ax0, w_ay0, w_bx0, w_by0;
    logic signed [POS_W-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [POS_W-1:0] w_dminor, w_dmajor;
    logic                    w_steep, w_swap;

    always_comb begin
        w_sx  = POS_W'(i_start_x);
        w_sy  = POS_W'(i_start_y);
        w_ex  = POS_W'(i_end_x);
        w_ey  = POS_W'(i_end_y);
        w_dx  = w_ex - w_sx;
        w_dy  = w_ey - w_sy;
        w_adx = w_dx[POS_W-1] ? -w_dx : w_dx;
        w_ady = w_dy[POS_W-1] ? -w_dy : w_dy;
        w_steep = w_ady > w_adx;

        // swap axes for steep lines
        w_ax0 = w_steep ? w_sy : w_sx;
        w_ay0 = w_steep ? w_sx : w_sy;
        w_bx0 = w_steep ? w_ey : w_ex;
        w_by0 = w_steep ? w_ex : w_ey;

        // order endpoints along the major axis
        w_swap = w_ax0 > w_bx0;
        w_ax = w_swap ? w_bx0 : w_ax0;
        w_ay = w_swap ? w_by0 : w_ay0;
        w_bx = w_swap ? w_ax0 : w_bx0;
        w_by = w_swap ? w_ay0 : w_by0;

        w_dmajor = w_bx - w_ax;
        w_dminor = w_by - w_ay;

        o_setup.steep       = w_steep;
        o_setup.major_pos   = w_ax;
        o_setup.major_end   = w_bx;
        o_setup.minor_pos   = w_ay;
        o_setup.major_delta = w_dmajor;
        o_setup.minor_delta = w_dminor[POS_W-1] ? -w_dminor : w_dminor;
        o_setup.error_term  = w_dmajor >>> 1;
        o_setup.minor_down  = !(w_ay < w_by);
    end

endmodule

// ===== rtl/line_pixel_rasterizer.sv =====
// an accepted word goes through the input register and then the output register
// throughput: one word per cycle while the master side accepts, set by the combinational line update
// a load word gives no output word; a step word gives one while a line is active
// synchronous active-low reset clears the active line and the pipeline valids and resets the limits
// after reset the limits are 127 wide and 159 high
`timescale 1ns / 1ps

module line_pixel_rasterizer
    import lpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [87:0]          s_axis_tdata,  // start_x, start_y, end_x, end_y, line_colour_in
    input  logic                 s_axis_tuser,  // kind

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,  // pixel_x, pixel_y, pixel_colour
    output logic                 m_axis_tuser,  // on_screen
    output logic                 m_axis_tlast   // last_pixel
);

    logic [LIMIT_W-1:0] r_width, r_height;

    logic                       r_in_valid;
    logic                       r_in_kind;
    logic signed [COORD_W-1:0]  r_in_sx, r_in_sy, r_in_ex, r_in_ey;
    logic [COLOUR_W-1:0]        r_in_colour;

    logic                       r_active;
    t_line_setup                r_line;
    logic [COLOUR_W-1:0]        r_colour;

    logic                       r_out_valid;
    logic signed [COORD_W-1:0]  r_out_x, r_out_y;
    logic                       r_out_on, r_out_last;
    logic [COLOUR_W-1:0]        r_out_colour;

    t_line_setup                w_setup;
    logic                       w_advance, w_load, w_step;
    logic signed [POS_W-1:0]    w_px, w_py, w_err;
    logic                       w_on, w_last;
    logic                       n_active;
    t_line_setup                n_line;

    lpr_setup u_setup (
        .i_start_x (r_in_sx),
        .i_start_y (r_in_sy),
        .i_end_x   (r_in_ex),
        .i_end_y   (r_in_ey),
        .o_setup   (w_setup)
    );

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_load        = r_in_valid && w_advance && (r_in_kind == KIND_LOAD);
    assign w_step        = r_in_valid && w_advance && (r_in_kind == KIND_STEP) && r_active;

    always_comb begin
        w_px   = r_line.steep ? r_line.minor_pos : r_line.major_pos;
        w_py   = r_line.steep ? r_line.major_pos : r_line.minor_pos;
        w_on   = !w_px[POS_W-1] && (w_px < $signed({4'b0, r_width})) &&
                 !w_py[POS_W-1] && (w_py < $signed({4'b0, r_height}));
        w_last = r_line.major_pos >= r_line.major_end;
        w_err  = r_line.error_term - r_line.minor_delta;

        n_line   = r_line;
        n_active = r_active;
        if (w_load) begin
            n_line   = w_setup;
            n_active = 1'b1;
        end else if (w_step) begin
            if (w_last) begin
                n_active = 1'b0;
            end else begin
                n_line.major_pos = r_line.major_pos + 16'sd1;
                if (w_err[POS_W-1]) begin
                    n_line.minor_pos  = r_line.minor_down ? r_line.minor_pos - 16'sd1
                                                          : r_line.minor_pos + 16'sd1;
                    n_line.error_term = w_err + r_line.major_delta;
                end else begin
                    n_line.error_term = w_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind   <= s_axis_tuser;
            r_in_sx     <= s_axis_tdata[14:0];
            r_in_sy     <= s_axis_tdata[29:15];
            r_in_ex     <= s_axis_tdata[44:30];
            r_in_ey     <= s_axis_tdata[59:45];
            r_in_colour <= s_axis_tdata[83:60];
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_line <= n_line;
        if (w_load) begin
            r_colour <= r_in_colour;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step;
        end
        if (w_step) begin
            r_out_x      <= w_px[COORD_W-1:0];
            r_out_y      <= w_py[COORD_W-1:0];
            r_out_on     <= w_on;
            r_out_last   <= w_last;
            r_out_colour <= r_colour;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_colour, r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_on;
    assign m_axis_tlast  = r_out_last;

    // error term stays within the major delta while drawing
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (!r_line.error_term[POS_W-1] &&
                      r_line.error_term <= r_line.major_delta))
        else $error("error term out of range");

    // minor delta never exceeds major delta
    a_delta_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_line.minor_delta <= r_line.major_delta))
        else $error("minor delta above major delta");

    // every non-final step moves one along the major axis
    a_major_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !w_last) |=> (r_line.major_pos == $past(r_line.major_pos) + 16'sd1))
        else $error("major position did not advance");

    // the final pixel ends the line
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_last) |=> (!r_active && r_out_valid && r_out_last))
        else $error("last pixel did not end the line");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the line pixel rasterizer with its own line-walk predictor
`timescale 1ns / 1ps

module tb
    import lpr_pkg::*;
();

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  ex;
        logic [COORD_W-1:0]  ey;
        logic [COLOUR_W-1:0] rgb;
    } t_word;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                visible;
        logic                tail;
        logic [COLOUR_W-1:0] rgb;
    } t_pixel;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = CFG_WIDTH;
    logic [LIMIT_W-1:0]  i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [87:0]         s_axis_tdata = '0;   // start_x, start_y, end_x, end_y, line_colour_in
    logic                s_axis_tuser = KIND_LOAD;  // kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [55:0]         m_axis_tdata;        // pixel_x, pixel_y, pixel_colour
    logic                m_axis_tuser;        // on_screen
    logic                m_axis_tlast;        // last_pixel

    line_pixel_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_word  words_to_send[$];
    t_pixel pixels_due[$];
    t_word  word_on_bus = '0;

    // shadow of the screen limits and of the line walk
    logic [LIMIT_W-1:0]        lim_x = RESET_WIDTH;
    logic [LIMIT_W-1:0]        lim_y = RESET_HEIGHT;
    logic                      drawing = 1'b0;
    logic                      swap_xy = 1'b0;
    logic signed [POS_W-1:0]   cur_major = '0;
    logic signed [POS_W-1:0]   last_major = '0;
    logic signed [POS_W-1:0]   cur_minor = '0;
    logic signed [POS_W-1:0]   run_len = '0;
    logic signed [POS_W-1:0]   rise = '0;
    logic signed [POS_W-1:0]   slope_acc = '0;
    logic                      go_down = 1'b0;
    logic [COLOUR_W-1:0]       line_rgb = '0;

    int errors = 0;
    int lines_loaded = 0;
    int pixels_checked = 0;
    int pixels_visible = 0;
    int limit_settings = 1;
    int idle_pct = 0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    bit long_hold_armed = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [POS_W-1:0] abs16(input logic signed [POS_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic rasterize(input t_word w);
        logic signed [POS_W-1:0] ax, ay, bx, by, t;
        logic signed [POS_W-1:0] px, py;
        logic vis, fin;
        t_pixel p;
        if (w.kind == KIND_LOAD) begin
            ax = {w.sx[COORD_W-1], w.sx};
            ay = {w.sy[COORD_W-1], w.sy};
            bx = {w.ex[COORD_W-1], w.ex};
            by = {w.ey[COORD_W-1], w.ey};
            swap_xy = abs16(by - ay) > abs16(bx - ax);
            if (swap_xy) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            cur_major = ax;
            last_major = bx;
            cur_minor = ay;
            run_len = bx - ax;
            rise = abs16(by - ay);
            slope_acc = run_len >>> 1;
            go_down = !(ay < by);
            line_rgb = w.rgb;
            drawing = 1'b1;
            lines_loaded++;
        end else if (drawing) begin
            px = swap_xy ? cur_minor : cur_major;
            py = swap_xy ? cur_major : cur_minor;
            vis = (px >= 0) && (px < $signed({4'b0, lim_x}))
                && (py >= 0) && (py < $signed({4'b0, lim_y}));
            fin = cur_major >= last_major;
            p.x = px[COORD_W-1:0];
            p.y = py[COORD_W-1:0];
            p.visible = vis;
            p.tail = fin;
            p.rgb = line_rgb;
            pixels_due.push_back(p);
            if (fin) begin
                drawing = 1'b0;
            end else begin
                slope_acc = slope_acc - rise;
                if (slope_acc < 0) begin
                    cur_minor = go_down ? cur_minor - 16'sd1 : cur_minor + 16'sd1;
                    slope_acc = slope_acc + run_len;
                end
                cur_major = cur_major + 16'sd1;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                rasterize(word_on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (words_to_send.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                    send_gap <= $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    t_word w;
                    w = words_to_send.pop_front();
                    word_on_bus <= w;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= w.kind;
                    s_axis_tdata <= {4'b0, w.rgb, w.ey, w.ex, w.sy, w.sx};
                end
            end
        end
    end

    // receiver, with one long hold-off while the sender still has words to offer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b1;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (long_hold_armed && !quiet && pixels_checked >= 60
                     && words_to_send.size() >= 20) begin
            long_hold_armed <= 1'b0;
            recv_gap <= 99;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            recv_gap <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_pixel p;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel x=%h y=%h", $realtime,
                         m_axis_tdata[14:0], m_axis_tdata[29:15]);
                errors++;
            end else begin
                p = pixels_due.pop_front();
                if (m_axis_tdata[14:0] !== p.x) begin
                    $display("%0t: pixel_x exp %h got %h", $realtime, p.x, m_axis_tdata[14:0]);
                    errors++;
                end
                if (m_axis_tdata[29:15] !== p.y) begin
                    $display("%0t: pixel_y exp %h got %h", $realtime, p.y, m_axis_tdata[29:15]);
                    errors++;
                end
                if (m_axis_tuser !== p.visible) begin
                    $display("%0t: on_screen exp %b got %b", $realtime, p.visible, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== p.tail) begin
                    $display("%0t: last_pixel exp %b got %b", $realtime, p.tail, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[53:30] !== p.rgb) begin
                    $display("%0t: pixel_colour exp %h got %h", $realtime, p.rgb,
                             m_axis_tdata[53:30]);
                    errors++;
                end
                pixels_checked++;
                if (p.visible) pixels_visible++;
            end
        end
    end

    task automatic queue_load(input int x0, input int y0, input int x1, input int y1,
                              input logic [COLOUR_W-1:0] rgb);
        t_word w;
        w.kind = KIND_LOAD;
        w.sx = COORD_W'(x0);
        w.sy = COORD_W'(y0);
        w.ex = COORD_W'(x1);
        w.ey = COORD_W'(y1);
        w.rgb = rgb;
        words_to_send.push_back(w);
    endtask

    // step words carry random content in the unused fields
    task automatic queue_steps(input int n);
        t_word w;
        logic [95:0] noise;
        for (int i = 0; i < n; i++) begin
            noise = {$urandom, $urandom, $urandom};
            w = noise[$bits(t_word)-1:0];
            w.kind = KIND_STEP;
            words_to_send.push_back(w);
        end
    endtask

    task automatic set_limit(input logic idx, input logic [LIMIT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) lim_x = v;
        else lim_y = v;
        limit_settings++;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (words_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic int near_edge(input int lim);
        case ($urandom_range(0, 2))
            0: return int'($urandom_range(0, 40)) - 20;
            1: return lim + int'($urandom_range(0, 40)) - 20;
            default: return int'($urandom_range(0, lim));
        endcase
    endfunction

    task automatic queue_random(input int target);
        int made, x0, y0, x1, y1, len, n;
        made = 0;
        while (made < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    n = $urandom_range(1, 3);
                    queue_steps(n);
                    made += n;
                end
                1: begin
                    // full-range endpoints, cut off by the next load
                    n = $urandom_range(0, 5);
                    queue_load(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                               COLOUR_W'($urandom));
                    queue_steps(n);
                    made += n + 1;
                end
                default: begin
                    x0 = near_edge(lim_x);
                    y0 = near_edge(lim_y);
                    x1 = x0 + int'($urandom_range(0, 40)) - 20;
                    y1 = y0 + int'($urandom_range(0, 40)) - 20;
                    len = ((x1 > x0) ? x1 - x0 : x0 - x1);
                    if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) len = (y1 > y0) ? y1 - y0 : y0 - y1;
                    len++;
                    case ($urandom_range(0, 9))
                        0: n = $urandom_range(0, len - 1);
                        1: n = len + $urandom_range(1, 3);
                        default: n = len;
                    endcase
                    queue_load(x0, y0, x1, y1, COLOUR_W'($urandom));
                    queue_steps(n);
                    made += n + 1;
                end
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words under the reset limits
        idle_pct = 20;
        queue_steps(1);
        queue_load(5, 7, 5, 7, 24'hFFFFFF);
        queue_steps(2);
        queue_load(125, -1, 128, 0, 24'h000000);
        queue_steps(4);
        queue_load(2, 160, 1, 157, 24'h123456);
        queue_steps(4);
        queue_load(0, 3, 3, 0, 24'h5A5A5A);
        queue_steps(4);
        queue_load(-16384, 16383, 16383, -16384, 24'hAAAAAA);
        queue_steps(2);
        queue_load(16383, -16384, 16383, -16384, 24'h555555);
        queue_steps(1);
        drain();

        set_limit(CFG_WIDTH, 12'd0);
        set_limit(CFG_HEIGHT, 12'd4095);
        @(negedge i_clk);
        idle_pct = 0;
        queue_random(80);
        drain();

        set_limit(CFG_WIDTH, 12'd4095);
        set_limit(CFG_HEIGHT, 12'd0);
        @(negedge i_clk);
        idle_pct = 25;
        queue_random(80);
        drain();

        set_limit(CFG_WIDTH, 12'd1);
        set_limit(CFG_HEIGHT, 12'd1);
        @(negedge i_clk);
        idle_pct = 10;
        queue_random(80);
        drain();

        set_limit(CFG_WIDTH, LIMIT_W'($urandom_range(1, 300)));
        set_limit(CFG_HEIGHT, LIMIT_W'($urandom_range(1, 300)));
        @(negedge i_clk);
        idle_pct = 30;
        queue_random(100);
        drain();

        // last part runs back to back on both sides
        set_limit(CFG_WIDTH, LIMIT_W'($urandom));
        set_limit(CFG_HEIGHT, LIMIT_W'($urandom));
        @(negedge i_clk);
        quiet = 1'b1;
        queue_random(80);
        drain();
        repeat (10) @(negedge i_clk);

        $display("covered %0d line loads under %0d limit settings", lines_loaded, limit_settings);
        $display("checked %0d pixels, %0d of them on screen", pixels_checked, pixels_visible);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpr_pkg.sv
rtl/lpr_setup.sv
rtl/line_pixel_rasterizer.sv
tb/tb.sv
